@@ rtl/teq_pkg.sv @@
// ============================================================================
// teq_pkg: shared types and constants of the timestamp-ordered event queue
// Holds queue sizing, field types, operation and status codes, and the
// command and status records passed between the controller and the datapath.
// ============================================================================
`default_nettype none

package teq_pkg;

  // Queue sizing.
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed port field widths.
  localparam int TIME_W    = 32;
  localparam int OUT_TAG_W = 16;
  localparam int OUT_CNT_W = 5;

  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [OUT_TAG_W-1:0] out_tag_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

  // Operation codes; the last code is a no-op.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath, valid for one cycle.
  typedef struct packed {
    logic    load;       // capture a new result beat
    logic    shift_in;   // insert the new entry in sorted position
    logic    shift_out;  // remove the head entry
    logic    show_head;  // report the head entry in the result
    status_e res_status; // status of the result beat
  } cmd_t;

  // Queue status back to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/timestamp_ordered_event_queue_core.sv @@
// ============================================================================
// timestamp_ordered_event_queue_core: bounded timestamp-sorted event queue
// Top level joining the controller and the sorted cell-chain datapath.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready) carries one operation beat: insert
//   (event_time, event_tag), pop the earliest entry, or peek at it. Entries
//   with equal timestamps leave in arrival order. The output channel
//   (out_valid/out_ready) returns exactly one result beat per operation with
//   status, head_time, head_tag and entry_count after the operation.
//   out_valid rises in the cycle after input acceptance. Every operation
//   completes without extra steps because all cells compare the timestamp in
//   parallel, so one item per cycle is sustained while out_ready is high.
//   When the receiver stalls, the result holds in the output register and a
//   new beat is taken only in the cycle the held result drains.
//   Reset empties the queue and clears out_valid at the next rising edge.
//   A full queue drops inserts with status full; pop or peek on an empty
//   queue returns status empty.
// ============================================================================
`default_nettype none

module timestamp_ordered_event_queue_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    operation,
  input  wire logic [teq_pkg::TIME_W-1:0]    event_time,
  input  wire logic [teq_pkg::OUT_TAG_W-1:0] event_tag,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [teq_pkg::TIME_W-1:0]         head_time,
  output logic [teq_pkg::OUT_TAG_W-1:0]      head_tag,
  output logic [teq_pkg::OUT_CNT_W-1:0]      entry_count
);

  teq_pkg::cmd_t cmd;
  teq_pkg::sts_t sts;

  // Handshake control and operation decode.
  teq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Sorted entry storage and result register.
  teq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .event_time  (event_time),
    .event_tag   (event_tag),
    .status      (status),
    .head_time   (head_time),
    .head_tag    (head_tag),
    .entry_count (entry_count)
  );

endmodule

`default_nettype wire

@@ rtl/teq_ctrl.sv @@
// ============================================================================
// teq_ctrl: controller of the timestamp-ordered event queue
// Runs the input and output handshakes, decodes each accepted operation
// against the queue status and issues one command to the datapath.
// ============================================================================
`default_nettype none

module teq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      operation,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire teq_pkg::sts_t   sts,
  output teq_pkg::cmd_t        cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  teq_pkg::op_e op;

  // A new item may enter whenever the result register is free or drains now.
  assign in_ready  = (state == S_IDLE) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state == S_RESULT);
  assign op        = teq_pkg::op_e'(operation);

  // Decode the operation against the current fill status.
  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.res_status = teq_pkg::ST_OK;
    unique case (op)
      teq_pkg::OP_INSERT: begin
        if (sts.full) begin
          cmd.res_status = teq_pkg::ST_FULL;
        end else begin
          cmd.shift_in = accept;
        end
      end
      teq_pkg::OP_POP: begin
        if (sts.empty) begin
          cmd.res_status = teq_pkg::ST_EMPTY;
        end else begin
          cmd.shift_out = accept;
          cmd.show_head = 1'b1;
        end
      end
      teq_pkg::OP_PEEK: begin
        if (sts.empty) begin
          cmd.res_status = teq_pkg::ST_EMPTY;
        end else begin
          cmd.show_head = 1'b1;
        end
      end
      default: begin
        cmd.res_status = teq_pkg::ST_OK;
      end
    endcase
  end

  // Next state of the result holding register.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (accept) begin
          state_next = S_RESULT;
        end else if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/teq_datapath.sv @@
// ============================================================================
// teq_datapath: sorted cell chain and result register
// Each cell compares the incoming timestamp with its own entry in parallel;
// an insert shifts the later entries up by one, a pop shifts all down by one.
// ============================================================================
`default_nettype none

module teq_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire teq_pkg::cmd_t                     cmd,
  output teq_pkg::sts_t                          sts,
  input  wire logic [teq_pkg::TIME_W-1:0]        event_time,
  input  wire logic [teq_pkg::OUT_TAG_W-1:0]     event_tag,
  output logic [1:0]                             status,
  output logic [teq_pkg::TIME_W-1:0]             head_time,
  output logic [teq_pkg::OUT_TAG_W-1:0]          head_tag,
  output logic [teq_pkg::OUT_CNT_W-1:0]          entry_count
);

  teq_pkg::time_t slot_time [teq_pkg::QUEUE_DEPTH];
  teq_pkg::tag_t  slot_tag  [teq_pkg::QUEUE_DEPTH];
  teq_pkg::cnt_t  fill;
  teq_pkg::cnt_t  fill_next;
  teq_pkg::tag_t  new_tag;

  // Per cell: the new entry belongs at or before this cell.
  logic [teq_pkg::QUEUE_DEPTH-1:0] later;

  assign new_tag   = teq_pkg::tag_t'(event_tag);
  assign sts.empty = (fill == '0);
  assign sts.full  = (fill == teq_pkg::cnt_t'(teq_pkg::QUEUE_DEPTH));

  // Fill level after the current command.
  always_comb begin
    fill_next = fill;
    if (cmd.shift_in) begin
      fill_next = fill + teq_pkg::cnt_t'(1);
    end else if (cmd.shift_out) begin
      fill_next = fill - teq_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Cell chain. Empty cells count as later than any timestamp, so the flags
  // form a suffix that starts at the insert position.
  for (genvar i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    assign later[i] = (teq_pkg::cnt_t'(i) >= fill) || (event_time < slot_time[i]);

    always_ff @(posedge clk) begin
      if (cmd.shift_in) begin
        if (i > 0 && later[(i > 0) ? i - 1 : 0]) begin
          slot_time[i] <= slot_time[(i > 0) ? i - 1 : 0];
          slot_tag[i]  <= slot_tag[(i > 0) ? i - 1 : 0];
        end else if (later[i]) begin
          slot_time[i] <= event_time;
          slot_tag[i]  <= new_tag;
        end
      end else if (cmd.shift_out && i < teq_pkg::QUEUE_DEPTH - 1) begin
        slot_time[i] <= slot_time[(i < teq_pkg::QUEUE_DEPTH - 1) ? i + 1 : i];
        slot_tag[i]  <= slot_tag[(i < teq_pkg::QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= cmd.res_status;
      head_time   <= cmd.show_head ? slot_time[0] : '0;
      head_tag    <= cmd.show_head ? teq_pkg::out_tag_t'(slot_tag[0]) : '0;
      entry_count <= teq_pkg::out_cnt_t'(fill_next);
    end
  end

endmodule

`default_nettype wire
